@@ src/i2cee_pkg.sv @@
package i2cee_pkg;

   localparam int ADDR_WIDTH_DEFAULT = 16;
   localparam int WAIT_WIDTH_DEFAULT = 16;

   localparam int DEV_WIDTH       = 7;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [DEV_WIDTH-1:0]      DEVICE_SELECT_RESET = 7'd80;
   localparam logic [CSR_DATA_WIDTH-1:0] POST_WAIT_RESET     = 16'd5000;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_SELECT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POST_WAIT     = 1'd1;

   // Direction bit appended to the device address in the control byte.
   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   // Item kinds on the request channel.
   localparam logic MODE_TICK    = 1'b0;
   localparam logic MODE_COMMAND = 1'b1;

   // Status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BUS_BUSY = 2'd1;
   localparam logic [1:0] STATUS_NACK     = 2'd2;
   localparam logic [1:0] STATUS_REJECTED = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_S_FREE   = 5'd1,
      PH_S_LOW    = 5'd2,
      PH_TX_LOW   = 5'd3,
      PH_TX_HIGH  = 5'd4,
      PH_ACK_LOW  = 5'd5,
      PH_ACK_HIGH = 5'd6,
      PH_RS_SETUP = 5'd7,
      PH_RS_HIGH  = 5'd8,
      PH_RS_LOW   = 5'd9,
      PH_RX_LOW   = 5'd10,
      PH_RX_HIGH  = 5'd11,
      PH_NK_LOW   = 5'd12,
      PH_NK_HIGH  = 5'd13,
      PH_P_LOW    = 5'd14,
      PH_P_HIGH   = 5'd15,
      PH_WAIT     = 5'd16
   } phase_type;

   // Which byte of the transaction is on the bus.
   typedef enum logic [1:0] {
      STAGE_CTRL    = 2'd0,
      STAGE_ADDR_HI = 2'd1,
      STAGE_ADDR_LO = 2'd2,
      STAGE_DATA    = 2'd3
   } stage_type;

   typedef struct packed {
      logic                      mode;
      logic                      sda_in;
      logic                      cmd_read;
      logic                      cmd_wide_addr;
      logic [15:0]               mem_addr;
      logic [7:0]                write_data;
   } req_type;

   typedef struct packed {
      logic                      scl_out;
      logic                      sda_out;
      logic                      busy_res;
      logic                      done_res;
      logic [1:0]                status;
      logic [7:0]                read_data;
   } rsp_type;

   typedef struct packed {
      logic [DEV_WIDTH-1:0]      device_select;
      logic [CSR_DATA_WIDTH-1:0] post_wait_ticks;
   } cfg_type;

endpackage

@@ src/i2cee_if.sv @@
interface i2cee_req_if;
   import i2cee_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface i2cee_rsp_if;
   import i2cee_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/i2cee_csr.sv @@
module i2cee_csr (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [i2cee_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [i2cee_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   output i2cee_pkg::cfg_type                        cfg
);
   import i2cee_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_SELECT: cfg_in.device_select   = csr_wdata[DEV_WIDTH-1:0];
            CSR_POST_WAIT:     cfg_in.post_wait_ticks = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_select   <= DEVICE_SELECT_RESET;
         cfg_ff.post_wait_ticks <= POST_WAIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/i2cee_core.sv @@
module i2cee_core #(
   parameter int ADDR_WIDTH = i2cee_pkg::ADDR_WIDTH_DEFAULT,
   parameter int WAIT_WIDTH = i2cee_pkg::WAIT_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  i2cee_pkg::cfg_type cfg,
   input  logic               step,
   input  i2cee_pkg::req_type req,
   output i2cee_pkg::rsp_type rsp
);
   import i2cee_pkg::*;

   phase_type             phase_ff,     phase_in;
   logic [3:0]            bit_count_ff, bit_count_in;
   logic [7:0]            shift_ff,     shift_in;
   logic [ADDR_WIDTH-1:0] addr_ff,      addr_in;
   logic [7:0]            data_ff,      data_in;
   logic                  op_read_ff,   op_read_in;
   logic                  op_wide_ff,   op_wide_in;
   stage_type             stage_ff,     stage_in;
   logic [WAIT_WIDTH-1:0] wait_ff,      wait_in;
   logic [1:0]            status_ff,    status_in;
   logic [7:0]            read_byte_ff, read_byte_in;

   logic                  done;
   logic                  rejected;
   logic [15:0]           addr_full;
   logic [3:0]            bit_count_inc;

   assign addr_full     = 16'(addr_ff);
   assign bit_count_inc = bit_count_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      op_read_in   = op_read_ff;
      op_wide_in   = op_wide_ff;
      stage_in     = stage_ff;
      wait_in      = wait_ff;
      status_in    = status_ff;
      read_byte_in = read_byte_ff;
      done         = 1'b0;
      rejected     = 1'b0;

      if (step) begin
         if (req.mode == MODE_COMMAND) begin
            if (phase_ff != PH_IDLE) begin
               rejected = 1'b1;
            end else begin
               op_read_in   = req.cmd_read;
               op_wide_in   = req.cmd_wide_addr;
               addr_in      = req.mem_addr[ADDR_WIDTH-1:0];
               data_in      = req.write_data;
               status_in    = STATUS_OK;
               bit_count_in = 4'd0;
               stage_in     = STAGE_CTRL;
               phase_in     = PH_S_FREE;
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_S_FREE: begin
                  if (!req.sda_in) begin
                     status_in = STATUS_BUS_BUSY;
                     phase_in  = PH_IDLE;
                     done      = 1'b1;
                  end else begin
                     phase_in = PH_S_LOW;
                  end
               end
               PH_S_LOW: begin
                  if (req.sda_in) begin
                     status_in = STATUS_BUS_BUSY;
                     phase_in  = PH_IDLE;
                     done      = 1'b1;
                  end else begin
                     stage_in     = STAGE_CTRL;
                     shift_in     = {cfg.device_select, RW_WRITE};
                     bit_count_in = 4'd0;
                     phase_in     = PH_TX_LOW;
                  end
               end
               PH_TX_LOW: begin
                  phase_in = PH_TX_HIGH;
               end
               PH_TX_HIGH: begin
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_count_inc;
                  phase_in     = bit_count_inc[3] ? PH_ACK_LOW : PH_TX_LOW;
               end
               PH_ACK_LOW: begin
                  phase_in = PH_ACK_HIGH;
               end
               PH_ACK_HIGH: begin
                  if (req.sda_in) begin
                     // The device did not acknowledge: close the bus with STOP.
                     status_in = STATUS_NACK;
                     phase_in  = PH_P_LOW;
                  end else begin
                     unique case (stage_ff)
                        STAGE_CTRL: begin
                           bit_count_in = 4'd0;
                           phase_in     = PH_TX_LOW;
                           if (op_wide_ff) begin
                              stage_in = STAGE_ADDR_HI;
                              shift_in = addr_full[15:8];
                           end else begin
                              stage_in = STAGE_ADDR_LO;
                              shift_in = addr_full[7:0];
                           end
                        end
                        STAGE_ADDR_HI: begin
                           stage_in     = STAGE_ADDR_LO;
                           shift_in     = addr_full[7:0];
                           bit_count_in = 4'd0;
                           phase_in     = PH_TX_LOW;
                        end
                        STAGE_ADDR_LO: begin
                           stage_in = STAGE_DATA;
                           if (op_read_ff) begin
                              phase_in = PH_RS_SETUP;
                           end else begin
                              shift_in     = data_ff;
                              bit_count_in = 4'd0;
                              phase_in     = PH_TX_LOW;
                           end
                        end
                        STAGE_DATA: begin
                           if (op_read_ff) begin
                              shift_in     = 8'd0;
                              bit_count_in = 4'd0;
                              phase_in     = PH_RX_LOW;
                           end else begin
                              phase_in = PH_P_LOW;
                           end
                        end
                        default: phase_in = PH_P_LOW;
                     endcase
                  end
               end
               PH_RS_SETUP: begin
                  phase_in = PH_RS_HIGH;
               end
               PH_RS_HIGH: begin
                  phase_in = PH_RS_LOW;
               end
               PH_RS_LOW: begin
                  shift_in     = {cfg.device_select, RW_READ};
                  bit_count_in = 4'd0;
                  phase_in     = PH_TX_LOW;
               end
               PH_RX_LOW: begin
                  phase_in = PH_RX_HIGH;
               end
               PH_RX_HIGH: begin
                  shift_in     = {shift_ff[6:0], req.sda_in};
                  bit_count_in = bit_count_inc;
                  phase_in     = bit_count_inc[3] ? PH_NK_LOW : PH_RX_LOW;
               end
               PH_NK_LOW: begin
                  phase_in = PH_NK_HIGH;
               end
               PH_NK_HIGH: begin
                  read_byte_in = shift_ff;
                  phase_in     = PH_P_LOW;
               end
               PH_P_LOW: begin
                  phase_in = PH_P_HIGH;
               end
               PH_P_HIGH: begin
                  wait_in = WAIT_WIDTH'(cfg.post_wait_ticks);
                  if (status_ff != STATUS_OK || wait_in == '0) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_WAIT: begin
                  wait_in = wait_ff - WAIT_WIDTH'(1);
                  if (wait_in == '0) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Line drives follow the phase the item leaves the sequencer in.
   always_comb begin
      unique case (phase_in)
         PH_S_LOW:    begin rsp.scl_out = 1'b1; rsp.sda_out = 1'b0;         end
         PH_TX_LOW:   begin rsp.scl_out = 1'b0; rsp.sda_out = shift_in[7];  end
         PH_TX_HIGH:  begin rsp.scl_out = 1'b1; rsp.sda_out = shift_in[7];  end
         PH_ACK_LOW,
         PH_RS_SETUP,
         PH_RX_LOW,
         PH_NK_LOW:   begin rsp.scl_out = 1'b0; rsp.sda_out = 1'b1;         end
         PH_RS_LOW:   begin rsp.scl_out = 1'b1; rsp.sda_out = 1'b0;         end
         PH_P_LOW:    begin rsp.scl_out = 1'b0; rsp.sda_out = 1'b0;         end
         PH_P_HIGH:   begin rsp.scl_out = 1'b1; rsp.sda_out = 1'b0;         end
         default:     begin rsp.scl_out = 1'b1; rsp.sda_out = 1'b1;         end
      endcase
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done;
      rsp.status    = rejected ? STATUS_REJECTED : status_in;
      rsp.read_data = read_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'd0;
         addr_ff      <= '0;
         data_ff      <= 8'd0;
         op_read_ff   <= 1'b0;
         op_wide_ff   <= 1'b0;
         stage_ff     <= STAGE_CTRL;
         wait_ff      <= '0;
         status_ff    <= STATUS_OK;
         read_byte_ff <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         addr_ff      <= addr_in;
         data_ff      <= data_in;
         op_read_ff   <= op_read_in;
         op_wide_ff   <= op_wide_in;
         stage_ff     <= stage_in;
         wait_ff      <= wait_in;
         status_ff    <= status_in;
         read_byte_ff <= read_byte_in;
      end
   end

   // The bit counter never runs past one full byte.
   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit counter ran past eight");

   // The post wait is only entered with a nonzero count and leaves at zero.
   a_wait_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAIT |-> wait_ff != '0)
      else $error("post wait running with zero count");

   // A command refused while busy leaves the transaction untouched.
   a_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      step && req.mode == MODE_COMMAND && phase_ff != PH_IDLE
      |=> $stable(status_ff) && $stable(phase_ff))
      else $error("rejected command disturbed the transaction");

   // Receiving data is only reachable through acknowledged bytes.
   a_rx_status_ok: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RX_LOW || phase_ff == PH_RX_HIGH) |-> status_ff == STATUS_OK)
      else $error("receiving after a failed acknowledge");

endmodule

@@ src/i2c_eeprom_byte_access_master.sv @@
// Channel  | Direction | Handshake      | Payload
// ---------+-----------+----------------+-----------------------------------------------
// req_chan | in        | valid / ready  | mode, sda_in, cmd_read, cmd_wide_addr,
//          |           |                | mem_addr, write_data
// rsp_chan | out       | valid / ready  | scl_out, sda_out, busy_res, done_res,
//          |           |                | status, read_data
// csr_*    | in        | csr_we         | csr_index selects the register, csr_wdata value
//
// One item is taken every clock cycle as long as rsp_chan keeps taking results. An
// accepted item sits in the input register while the sequencer works out its result
// combinationally, and the result is registered in the result register for rsp_chan.
// Reset clears the sequencer and both handshake stages; nothing is swept.
// When rsp_chan stalls, the result register and the input register hold their items,
// and req_chan.ready drops only once both are full.
module i2c_eeprom_byte_access_master #(
   parameter int ADDR_WIDTH = i2cee_pkg::ADDR_WIDTH_DEFAULT,
   parameter int WAIT_WIDTH = i2cee_pkg::WAIT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   i2cee_req_if.sink                             req_chan,
   i2cee_rsp_if.source                           rsp_chan,
   input  logic                                  csr_we,
   input  logic [i2cee_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cee_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import i2cee_pkg::*;

   cfg_type cfg;
   rsp_type core_rsp;

   // Input stage: holds one accepted item until the sequencer consumes it.
   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff;

   // Output stage: holds one result until the sink takes it.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic    advance;
   logic    step;
   logic    req_accept;

   // The pipeline moves whenever the result register is free or being emptied.
   assign advance    = !rsp_valid_ff || rsp_chan.ready;
   assign step       = req_valid_ff && advance;
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign req_valid_in = req_accept || (req_valid_ff && !advance);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_chan.ready);

   i2cee_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cee_core #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (step),
      .req   (req_data_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset; they load only alongside a valid item.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_data_ff <= req_chan.data;
      end
      if (step) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

import i2cee_pkg::*;

class eeprom_master_scoreboard;
   // Register copies.
   logic [DEV_WIDTH-1:0]      dev_addr;
   logic [CSR_DATA_WIDTH-1:0] settle_ticks;

   // Sequencer copy.
   phase_type   phase;
   stage_type   stage;
   logic [3:0]  bits_done;
   logic [7:0]  shifter;
   logic [15:0] word_addr;
   logic [7:0]  store_byte;
   logic        op_read;
   logic        op_wide;
   logic [15:0] wait_left;
   logic [1:0]  outcome;
   logic [7:0]  fetched_byte;

   rsp_type     due_results[$];

   int          mismatches;
   int          checked;
   int          worked;
   int          completed;
   int          reads_done;
   int          nacked;
   int          bus_faults;
   int          refused;

   function new();
      dev_addr     = DEVICE_SELECT_RESET;
      settle_ticks = POST_WAIT_RESET;
      phase        = PH_IDLE;
      stage        = STAGE_CTRL;
      bits_done    = '0;
      shifter      = '0;
      word_addr    = '0;
      store_byte   = '0;
      op_read      = 1'b0;
      op_wide      = 1'b0;
      wait_left    = '0;
      outcome      = STATUS_OK;
      fetched_byte = '0;
   endfunction

   function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      case (idx)
         CSR_DEVICE_SELECT: dev_addr = value[DEV_WIDTH-1:0];
         CSR_POST_WAIT:     settle_ticks = value;
         default:           ;
      endcase
   endfunction

   function void load_byte(logic [7:0] b);
      shifter   = b;
      bits_done = '0;
      phase     = PH_TX_LOW;
   endfunction

   // One bus phase; returns 1 when the transaction ends on this tick.
   function bit advance_sequencer(logic sda);
      case (phase)
         PH_S_FREE: begin
            if (!sda) begin
               outcome = STATUS_BUS_BUSY;
               phase = PH_IDLE;
               return 1'b1;
            end
            phase = PH_S_LOW;
         end
         PH_S_LOW: begin
            if (sda) begin
               outcome = STATUS_BUS_BUSY;
               phase = PH_IDLE;
               return 1'b1;
            end
            stage = STAGE_CTRL;
            load_byte({dev_addr, RW_WRITE});
         end
         PH_TX_LOW: phase = PH_TX_HIGH;
         PH_TX_HIGH: begin
            shifter   = shifter << 1;
            bits_done = bits_done + 4'd1;
            phase     = (bits_done >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
         end
         PH_ACK_LOW: phase = PH_ACK_HIGH;
         PH_ACK_HIGH: begin
            if (sda) begin
               outcome = STATUS_NACK;
               phase = PH_P_LOW;
            end else begin
               case (stage)
                  STAGE_CTRL: begin
                     if (op_wide) begin
                        stage = STAGE_ADDR_HI;
                        load_byte(word_addr[15:8]);
                     end else begin
                        stage = STAGE_ADDR_LO;
                        load_byte(word_addr[7:0]);
                     end
                  end
                  STAGE_ADDR_HI: begin
                     stage = STAGE_ADDR_LO;
                     load_byte(word_addr[7:0]);
                  end
                  STAGE_ADDR_LO: begin
                     stage = STAGE_DATA;
                     if (op_read) phase = PH_RS_SETUP;
                     else load_byte(store_byte);
                  end
                  default: begin
                     if (op_read) begin
                        shifter   = '0;
                        bits_done = '0;
                        phase     = PH_RX_LOW;
                     end else begin
                        phase = PH_P_LOW;
                     end
                  end
               endcase
            end
         end
         PH_RS_SETUP: phase = PH_RS_HIGH;
         PH_RS_HIGH:  phase = PH_RS_LOW;
         PH_RS_LOW:   load_byte({dev_addr, RW_READ});
         PH_RX_LOW:   phase = PH_RX_HIGH;
         PH_RX_HIGH: begin
            shifter   = {shifter[6:0], sda};
            bits_done = bits_done + 4'd1;
            phase     = (bits_done >= 4'd8) ? PH_NK_LOW : PH_RX_LOW;
         end
         PH_NK_LOW: phase = PH_NK_HIGH;
         PH_NK_HIGH: begin
            fetched_byte = shifter;
            phase = PH_P_LOW;
         end
         PH_P_LOW: phase = PH_P_HIGH;
         PH_P_HIGH: begin
            wait_left = settle_ticks;
            if (outcome != STATUS_OK || wait_left == '0) begin
               phase = PH_IDLE;
               return 1'b1;
            end
            phase = PH_WAIT;
         end
         PH_WAIT: begin
            wait_left = wait_left - 16'd1;
            if (wait_left == '0) begin
               phase = PH_IDLE;
               return 1'b1;
            end
         end
         default: phase = PH_IDLE;
      endcase
      return 1'b0;
   endfunction

   function void note_request(req_type r);
      rsp_type want;
      logic [1:0] st;
      bit fin;
      st  = outcome;
      fin = 1'b0;
      if (r.mode == MODE_COMMAND) begin
         if (phase != PH_IDLE) begin
            st = STATUS_REJECTED;
            refused++;
         end else begin
            op_read    = r.cmd_read;
            op_wide    = r.cmd_wide_addr;
            word_addr  = r.mem_addr;
            store_byte = r.write_data;
            outcome    = STATUS_OK;
            st         = STATUS_OK;
            bits_done  = '0;
            stage      = STAGE_CTRL;
            phase      = PH_S_FREE;
            worked++;
         end
      end else if (phase != PH_IDLE) begin
         fin = advance_sequencer(r.sda_in);
         st  = outcome;
         worked++;
         if (fin) begin
            case (outcome)
               STATUS_OK: begin
                  completed++;
                  if (op_read) reads_done++;
               end
               STATUS_NACK:     nacked++;
               STATUS_BUS_BUSY: bus_faults++;
               default:         ;
            endcase
         end
      end

      case (phase)
         PH_S_LOW:    {want.scl_out, want.sda_out} = 2'b10;
         PH_TX_LOW:   {want.scl_out, want.sda_out} = {1'b0, shifter[7]};
         PH_TX_HIGH:  {want.scl_out, want.sda_out} = {1'b1, shifter[7]};
         PH_ACK_LOW, PH_RS_SETUP, PH_RX_LOW, PH_NK_LOW:
                      {want.scl_out, want.sda_out} = 2'b01;
         PH_RS_LOW:   {want.scl_out, want.sda_out} = 2'b10;
         PH_P_LOW:    {want.scl_out, want.sda_out} = 2'b00;
         PH_P_HIGH:   {want.scl_out, want.sda_out} = 2'b10;
         default:     {want.scl_out, want.sda_out} = 2'b11;
      endcase
      want.busy_res  = (phase != PH_IDLE);
      want.done_res  = fin;
      want.status    = st;
      want.read_data = fetched_byte;
      due_results.push_back(want);
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      checked++;
      if (due_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: result with nothing pending: scl=%0b sda=%0b busy=%0b done=%0b",
                     got.scl_out, got.sda_out, got.busy_res, got.done_res);
         return;
      end
      want = due_results.pop_front();
      if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
          got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
          got.status !== want.status || got.read_data !== want.read_data) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: result %0d expected scl=%0b sda=%0b busy=%0b done=%0b st=%0d rd=%02h",
                     checked, want.scl_out, want.sda_out, want.busy_res, want.done_res,
                     want.status, want.read_data);
            $display("       got              scl=%0b sda=%0b busy=%0b done=%0b st=%0d rd=%02h",
                     got.scl_out, got.sda_out, got.busy_res, got.done_res,
                     got.status, got.read_data);
         end
      end
   endfunction
endclass

module tb;
   // Far above the slowest correct run, which handles roughly 800 items with
   // idling on both sides and the long receiver hold.
   localparam int CYCLE_LIMIT = 50_000;

   // How a transaction is steered through the slave's side of the bus.
   typedef enum int {
      FAULT_NONE,      // bus free, every byte acknowledged
      FAULT_LINE_LOW,  // SDA already low when the start is checked
      FAULT_LINE_HIGH, // SDA fails to follow the start condition down
      FAULT_NACK,      // one chosen acknowledge comes back high
      FAULT_NOISE      // random SDA everywhere
   } bus_fault_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   i2cee_req_if req_chan ();
   i2cee_rsp_if rsp_chan ();

   eeprom_master_scoreboard sb = new();

   int cycle_count = 0;
   int results_seen = 0;
   int hold_left = 0;
   bit held = 1'b0;
   // While set, neither side inserts idle cycles.
   bit steady = 1'b0;

   i2c_eeprom_byte_access_master uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run is bounded by a plain cycle counter.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL i2c_eeprom_byte_access_master");
         $finish;
      end
   end

   // Result side. Every accepted result goes to the scoreboard. Ready drops at
   // random about a quarter of the time, except in the steady stretch. Once,
   // early in the run, ready is held low while the sender keeps offering
   // items, so both internal stages fill and req_chan.ready must drop.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result(rsp_chan.data);
            results_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (results_seen >= 40 && !held) begin
            held = 1'b1;
            hold_left = 63;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(99) >= 26);
         end
      end
   end

   // Random contents for every field; callers then set the fields that matter.
   function automatic req_type random_item();
      logic [31:0] r;
      r = $urandom;
      return r[$bits(req_type)-1:0];
   endfunction

   // Offers one item, possibly after a few idle cycles, and returns at the edge
   // where it is accepted. The predictor is updated at that same edge, so the
   // caller sees the sequencer state that the next item will meet. Valid stays
   // high on return; the next call or the caller decides what happens to it.
   task automatic send_req(req_type item);
      while (!steady && $urandom_range(99) < 26) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= item;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_request(item);
   endtask

   task automatic send_tick(logic sda);
      req_type item;
      item = random_item();
      item.mode   = MODE_TICK;
      item.sda_in = sda;
      send_req(item);
   endtask

   // Registers may only change with the block idle and nothing in flight, so
   // this waits for every pending result and then for a few cycles of margin.
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      req_chan.valid <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
      csr_we <= 1'b0;
   endtask

   // Issues one command and then plays the slave: each tick carries the SDA
   // level that a real EEPROM would present in the predicted phase, with a
   // fault injected where asked. Phases that ignore SDA get a random level.
   // A small share of the items are commands, which the busy block must refuse.
   // Returns once the predicted sequencer is idle again.
   task automatic run_transaction(logic rd, logic wide, logic [15:0] addr, logic [7:0] data,
                                  logic [7:0] rx_byte, bus_fault_type fault, int nack_at,
                                  int reject_pct);
      req_type item;
      int acks_seen;
      int rx_bits;
      acks_seen = 0;
      rx_bits   = 0;
      item = random_item();
      item.mode          = MODE_COMMAND;
      item.cmd_read      = rd;
      item.cmd_wide_addr = wide;
      item.mem_addr      = addr;
      item.write_data    = data;
      send_req(item);
      while (sb.phase != PH_IDLE) begin
         item = random_item();
         if ($urandom_range(99) < reject_pct) begin
            item.mode = MODE_COMMAND;
         end else begin
            item.mode = MODE_TICK;
            if (fault != FAULT_NOISE) begin
               case (sb.phase)
                  PH_S_FREE:   item.sda_in = (fault != FAULT_LINE_LOW);
                  PH_S_LOW:    item.sda_in = (fault == FAULT_LINE_HIGH);
                  PH_ACK_HIGH: begin
                     item.sda_in = (fault == FAULT_NACK && acks_seen == nack_at);
                     acks_seen++;
                  end
                  PH_RX_HIGH: begin
                     item.sda_in = rx_byte[3'(7 - rx_bits)];
                     rx_bits++;
                  end
                  default: ;
               endcase
            end
         end
         send_req(item);
      end
   endtask

   // Random transactions until the given number of working items has gone in.
   // Most are well-formed with random content; the rest carry faults or noise.
   // Short runs of ignored idle ticks fall between transactions.
   task automatic random_traffic(int target);
      int start_count;
      int pick;
      bus_fault_type fault;
      start_count = sb.worked;
      while (sb.worked - start_count < target) begin
         pick = $urandom_range(99);
         if (pick < 70)      fault = FAULT_NONE;
         else if (pick < 82) fault = FAULT_NACK;
         else if (pick < 88) fault = FAULT_LINE_LOW;
         else if (pick < 94) fault = FAULT_LINE_HIGH;
         else                fault = FAULT_NOISE;
         run_transaction(1'($urandom_range(1)), 1'($urandom_range(1)),
                         16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)),
                         8'($urandom_range(8'hFF)), fault, $urandom_range(3), 2);
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_tick(1'($urandom_range(1)));
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first with the reset register values. Ticks while idle
      // are ignored. The first write gets no acknowledge on its data byte, so
      // it stops without the post wait; stray commands meanwhile are refused.
      send_tick(1'b0);
      send_tick(1'b1);
      run_transaction(1'b0, 1'b0, 16'hFF00, 8'hFF, 8'h00, FAULT_NACK, 2, 2);

      // Highest device address and no post wait: done comes with the stop.
      write_reg(CSR_DEVICE_SELECT, {9'($urandom), 7'd127});
      write_reg(CSR_POST_WAIT, 16'd0);
      run_transaction(1'b1, 1'b1, 16'hFFFF, 8'h00, 8'hFF, FAULT_NONE, 0, 0);
      // Narrow addressing sends only the low byte of the address.
      run_transaction(1'b1, 1'b0, 16'hAB12, 8'hFF, 8'hA5, FAULT_NONE, 0, 0);
      // Bus not free: line low before the start, then line not following it.
      run_transaction(1'b0, 1'b0, 16'h1234, 8'h55, 8'h00, FAULT_LINE_LOW, 0, 0);
      run_transaction(1'b1, 1'b1, 16'h4321, 8'hAA, 8'h00, FAULT_LINE_HIGH, 0, 0);
      // No acknowledge on the control byte, the address bytes and the read
      // control byte after the repeated start.
      run_transaction(1'b0, 1'b0, 16'h00C3, 8'h3C, 8'h00, FAULT_NACK, 0, 0);
      run_transaction(1'b0, 1'b1, 16'h7E81, 8'h81, 8'h00, FAULT_NACK, 1, 0);
      run_transaction(1'b1, 1'b1, 16'h0F0F, 8'h00, 8'hC3, FAULT_NACK, 2, 0);
      run_transaction(1'b1, 1'b1, 16'hF0F0, 8'h00, 8'h3C, FAULT_NACK, 3, 0);

      // Lowest device address, one-tick post wait.
      write_reg(CSR_DEVICE_SELECT, 16'd0);
      write_reg(CSR_POST_WAIT, 16'd1);
      run_transaction(1'b0, 1'b0, 16'h00A5, 8'hC3, 8'h00, FAULT_NONE, 0, 0);

      // Random part across three register settings. The first stretch runs
      // with no idling on either side.
      steady = 1'b1;
      random_traffic(60);
      steady = 1'b0;
      random_traffic(20);

      write_reg(CSR_DEVICE_SELECT, {9'($urandom), 7'd127});
      write_reg(CSR_POST_WAIT, 16'd0);
      random_traffic(30);

      write_reg(CSR_DEVICE_SELECT, 16'($urandom_range(16'hFFFF)));
      write_reg(CSR_POST_WAIT, 16'($urandom_range(2, 40)));
      random_traffic(30);

      req_chan.valid <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d finished transactions: %0d clean (%0d reads), %0d no-ack,",
               sb.completed + sb.nacked + sb.bus_faults, sb.completed, sb.reads_done,
               sb.nacked);
      $display("  %0d bus-not-free, %0d refused commands; %0d results checked, %0d wrong.",
               sb.bus_faults, sb.refused, sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
         $display("PASS i2c_eeprom_byte_access_master");
      end else begin
         $display("FAIL i2c_eeprom_byte_access_master");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
src/i2cee_pkg.sv
src/i2cee_if.sv
src/i2cee_csr.sv
src/i2cee_core.sv
src/i2c_eeprom_byte_access_master.sv
tb/tb.sv
